/* rtl/dp2g_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dp2g_pkg: shared types and helpers of the decimal power-of-two generator
// Holds the sequencer state type, the digit unit result and the divide by ten.
// ----------------------------------------------------------------------------
package dp2g_pkg;

    localparam int RESULT_LIMIT = 32;
    localparam int MIN_EXPONENT = -512;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_PASS,
        S_TAIL,
        S_FIN,
        S_GATHER,
        S_SEND
    } t_state;

    // One digit of a multiply-with-carry pass: new digit and carry out.
    typedef struct packed {
        logic [2:0] carry;
        logic [3:0] digit;
    } t_digit_res;

    // Split a small product into quotient and remainder by ten.
    function automatic t_digit_res f_div10(input logic [6:0] v);
        t_digit_res res;
        logic [6:0] rem;
        logic [2:0] q;
        rem = v;
        q   = 3'd0;
        for (int i = 0; i < 7; i++) begin
            if (rem >= 7'd10) begin
                rem = rem - 7'd10;
                q   = q + 3'd1;
            end
        end
        res.digit = rem[3:0];
        res.carry = q;
        return res;
    endfunction

endpackage
`default_nettype wire

/* rtl/dp2g_digit_alu.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dp2g_digit_alu: shared digit multiply-with-carry unit
// Computes digit * (2 or 5) + carry and splits the sum into digit and carry.
// ----------------------------------------------------------------------------
module dp2g_digit_alu (
    input  logic               i_base_five,
    input  logic [3:0]         i_digit,
    input  logic [2:0]         i_carry,
    output dp2g_pkg::t_digit_res o_res
);
    import dp2g_pkg::*;

    logic [6:0] w_sum;

    always_comb begin
        if (i_base_five) begin
            w_sum = ({3'b000, i_digit} << 2) + {3'b000, i_digit} + {4'b0000, i_carry};
        end else begin
            w_sum = ({3'b000, i_digit} << 1) + {4'b0000, i_carry};
        end
    end

    assign o_res = f_div10(w_sum);

endmodule
`default_nettype wire

/* rtl/dp2g_digit_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dp2g_digit_store: digit memory, one write and one registered read port
// Holds one BCD digit per entry, least significant digit at address zero.
// ----------------------------------------------------------------------------
module dp2g_digit_store #(
    parameter int AW = 9
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [3:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [3:0]    o_rdata
);
    logic [3:0] r_mem [0:(1<<AW)-1];
    logic [3:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* rtl/decimal_power_of_two_generator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_power_of_two_generator: exact decimal digits of 2^n
// Builds 2^n (or 5^|n| for negative n) digit by digit and streams BCD groups.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) takes one word: the signed exponent n.
//   Exponents below -512 are clamped to -512. o_stall stays high from the
//   accepting edge until the last result group has been taken.
//   For n >= 0 the store starts at one and is doubled n times; for n < 0 it is
//   multiplied by five |n| times and the decimal exponent is n.
//   Each pass walks the digit store through the shared digit unit at one digit
//   per cycle, then a tail step appends any leftover carry; the time for one
//   word grows with |n| and the digit count, limited by the single memory read
//   port and the shared digit unit.
//   Output channel (o_valid / i_stall) then sends ceil(count / DIGITS_PER_GROUP)
//   groups (at most 32), low group first, each gathered digit by digit from
//   the store, with a setup step before the first group;
//   o_last_group flags the final one.
//   While i_stall is high the current group and its fields hold steady.
//   Reset (i_rst_n low, synchronous) returns to idle with an empty store; the
//   store needs no clearing pass since only written entries are ever read.
// ----------------------------------------------------------------------------
module decimal_power_of_two_generator #(
    parameter int MAX_DIGITS       = 512,
    parameter int DIGITS_PER_GROUP = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // exponent channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [10:0] i_binary_exponent,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [63:0]        o_digit_group,
    output logic [4:0]         o_group_index,
    output logic [9:0]         o_digit_count,
    output logic signed [9:0]  o_decimal_exponent,
    output logic               o_last_group
);
    import dp2g_pkg::*;

    // address, length, position and in-group digit widths
    localparam int AW = $clog2(MAX_DIGITS);
    localparam int LW = $clog2(MAX_DIGITS + 1);
    localparam int PW = $clog2(MAX_DIGITS + DIGITS_PER_GROUP + 1);
    localparam int JW = (DIGITS_PER_GROUP > 1) ? $clog2(DIGITS_PER_GROUP) : 1;

    t_state r_state, n_state;

    logic [LW-1:0]      r_len, n_len;         // digits held
    logic [9:0]         r_passes, n_passes;   // passes still to run
    logic               r_neg, n_neg;         // multiply by five
    logic [2:0]         r_carry, n_carry;
    logic [PW-1:0]      r_pos, n_pos;         // digit position being worked
    logic [JW-1:0]      r_j, n_j;             // digit within current group
    logic [63:0]        r_word, n_word;       // group being assembled
    logic [4:0]         r_g, n_g;             // group being assembled
    logic signed [9:0]  r_dec_exp, n_dec_exp;
    logic [63:0]        r_out_word, n_out_word;
    logic [4:0]         r_out_g, n_out_g;
    logic               r_out_last, n_out_last;

    // store and digit unit hookup
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [3:0]         mem_wdata;
    logic [3:0]         mem_rdata;
    t_digit_res         alu_res;

    // decoded conditions
    logic               in_accept;
    logic               out_accept;
    logic signed [10:0] sat_n;
    logic [10:0]        mag_n;
    logic               pass_last;
    logic               passes_done;
    logic               grow;
    logic               group_done;
    logic               group_last;
    logic [3:0]         gather_nib;
    logic [LW+9:0]      len_wide;
    logic [LW+9:0]      len_m1_wide;

    assign in_accept  = i_valid && !o_stall;
    assign out_accept = o_valid && !i_stall;

    // clamp the exponent and take its magnitude as the pass count
    always_comb begin
        sat_n = (i_binary_exponent < 11'(MIN_EXPONENT)) ? 11'(MIN_EXPONENT)
                                                         : i_binary_exponent;
        mag_n = sat_n[10] ? 11'(-sat_n) : sat_n;
    end

    assign pass_last   = (r_pos + PW'(1)) == PW'(r_len);
    assign passes_done = (r_passes == 10'd1);
    assign grow        = (r_carry != 3'd0) && (r_len < LW'(MAX_DIGITS));
    assign group_done  = (r_j == JW'(DIGITS_PER_GROUP - 1));
    assign group_last  = ((r_pos + PW'(1)) >= PW'(r_len)) || (&r_g);
    assign gather_nib  = (r_pos < PW'(r_len)) ? mem_rdata : 4'h0;
    assign len_wide    = {10'd0, r_len};
    assign len_m1_wide = {10'd0, r_len - LW'(1)};

    dp2g_digit_store #(
        .AW (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (n_pos[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    dp2g_digit_alu u_alu (
        .i_base_five (r_neg),
        .i_digit     (mem_rdata),
        .i_carry     (r_carry),
        .o_res       (alu_res)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = (r_passes == 10'd0) ? S_FIN : S_PASS;
            end
            S_PASS: begin
                if (pass_last) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                n_state = passes_done ? S_FIN : S_PASS;
            end
            S_FIN: begin
                n_state = S_GATHER;
            end
            S_GATHER: begin
                if (group_done) begin
                    n_state = S_SEND;
                end
            end
            S_SEND: begin
                if (out_accept) begin
                    n_state = r_out_last ? S_IDLE : S_GATHER;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and store control
    always_comb begin
        n_len      = r_len;
        n_passes   = r_passes;
        n_neg      = r_neg;
        n_carry    = r_carry;
        n_pos      = r_pos;
        n_j        = r_j;
        n_word     = r_word;
        n_g        = r_g;
        n_dec_exp  = r_dec_exp;
        n_out_word = r_out_word;
        n_out_g    = r_out_g;
        n_out_last = r_out_last;
        mem_we     = 1'b0;
        mem_waddr  = r_pos[AW-1:0];
        mem_wdata  = alu_res.digit;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    // seed the store with the single digit one
                    mem_we    = 1'b1;
                    mem_waddr = '0;
                    mem_wdata = 4'd1;
                    n_len     = LW'(1);
                    n_neg     = sat_n[10];
                    n_passes  = mag_n[9:0];
                    n_dec_exp = sat_n[9:0];
                    n_pos     = '0;
                end
            end
            S_START: begin
                n_pos   = '0;
                n_carry = 3'd0;
            end
            S_PASS: begin
                // rewrite this digit, advance to the next one
                mem_we  = 1'b1;
                n_carry = alu_res.carry;
                if (!pass_last) begin
                    n_pos = r_pos + PW'(1);
                end
            end
            S_TAIL: begin
                // append the leftover carry as a new top digit
                if (grow) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_len[AW-1:0];
                    mem_wdata = {1'b0, r_carry};
                    n_len     = r_len + LW'(1);
                end
                n_carry  = 3'd0;
                n_passes = r_passes - 10'd1;
                n_pos    = '0;
            end
            S_FIN: begin
                if (!r_neg) begin
                    n_dec_exp = len_m1_wide[9:0];
                end
                n_pos  = '0;
                n_j    = '0;
                n_word = '0;
                n_g    = 5'd0;
            end
            S_GATHER: begin
                n_word[4*r_j +: 4] = gather_nib;
                n_pos = r_pos + PW'(1);
                if (group_done) begin
                    n_out_word = n_word;
                    n_out_g    = r_g;
                    n_out_last = group_last;
                end else begin
                    n_j = r_j + JW'(1);
                end
            end
            S_SEND: begin
                // hold the read on the first digit of the next group
                if (out_accept && !r_out_last) begin
                    n_g    = r_g + 5'd1;
                    n_j    = '0;
                    n_word = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len     <= '0;
            r_passes  <= 10'd0;
            r_carry   <= 3'd0;
            r_dec_exp <= 10'sd0;
        end else begin
            r_state   <= n_state;
            r_len     <= n_len;
            r_passes  <= n_passes;
            r_carry   <= n_carry;
            r_dec_exp <= n_dec_exp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg      <= n_neg;
        r_pos      <= n_pos;
        r_j        <= n_j;
        r_word     <= n_word;
        r_g        <= n_g;
        r_out_word <= n_out_word;
        r_out_g    <= n_out_g;
        r_out_last <= n_out_last;
    end

    assign o_stall            = (r_state != S_IDLE);
    assign o_valid            = (r_state == S_SEND);
    assign o_digit_group      = r_out_word;
    assign o_group_index      = r_out_g;
    assign o_digit_count      = len_wide[9:0];
    assign o_decimal_exponent = r_dec_exp;
    assign o_last_group       = r_out_last;

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(MAX_DIGITS))
        else $error("digit count beyond store depth");

    a_pass_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PASS) |-> (r_pos < PW'(r_len)))
        else $error("pass reads beyond the held digits");

    a_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_START) && (r_len == LW'(1)))
        else $error("accepted exponent did not seed the store");

    a_passes_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_passes == 10'd0) && (r_len != '0))
        else $error("result sent before all passes ran");
`endif

endmodule
`default_nettype wire
